// File: sv/imm_pkg.sv
package imm_pkg;

    localparam int MAX_DIM = 8;
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * DIM_W;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int DATA_W  = 32;
    localparam int CFG_W   = 4;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    localparam logic CFG_NUM_ROWS = 1'b0;
    localparam logic CFG_NUM_COLS = 1'b1;

    typedef struct packed {
        logic              a_we;
        logic              b_we;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] a_rd_addr;
        logic [ADDR_W-1:0] b_rd_addr;
        logic              first_term;
        logic              last_term;
        logic              out_load;
        logic [DIM_W-1:0]  out_row;
        logic [DIM_W-1:0]  out_col;
        logic              out_last;
    } imm_cmd_t;

    typedef struct packed {
        logic dot_done;
        logic out_free;
    } imm_status_t;

    // register value 0 acts as 1, above MAX_DIM acts as MAX_DIM
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > CFG_W'(MAX_DIM)) begin
            r = CFG_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// File: sv/imm_ctrl.sv
module imm_ctrl
    import imm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_opcode,
    input  logic [DIM_W-1:0]  s_row_index,
    input  logic [DIM_W-1:0]  s_col_index,
    input  imm_status_t       status,
    output imm_cmd_t          cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [DIM_W-1:0] i_reg, i_next;
    logic [DIM_W-1:0] j_reg, j_next;
    logic [DIM_W-1:0] k_reg, k_next;
    logic [CFG_W-1:0] rows_cfg_reg, cols_cfg_reg;
    logic [CFG_W-1:0] rows, cols;
    logic             k_at_end, j_at_end, i_at_end;
    logic             row_ok_a, row_ok_b, col_ok;

    assign rows = clamp_dim(rows_cfg_reg);
    assign cols = clamp_dim(cols_cfg_reg);

    assign k_at_end = ({1'b0, k_reg} == cols - CFG_W'(1));
    assign j_at_end = ({1'b0, j_reg} == cols - CFG_W'(1));
    assign i_at_end = ({1'b0, i_reg} == rows - CFG_W'(1));

    assign row_ok_a = ({1'b0, s_row_index} < rows);
    assign row_ok_b = ({1'b0, s_row_index} < cols);
    assign col_ok   = ({1'b0, s_col_index} < cols);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= CFG_W'(MAX_DIM);
            cols_cfg_reg <= CFG_W'(MAX_DIM);
        end else if (cfg_we) begin
            if (cfg_index == CFG_NUM_ROWS) begin
                rows_cfg_reg <= cfg_wdata;
            end else begin
                cols_cfg_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        s_ready    = 1'b0;

        cmd            = '0;
        cmd.wr_addr    = {s_row_index, s_col_index};
        cmd.a_rd_addr  = {i_reg, k_reg};
        cmd.b_rd_addr  = {k_reg, j_reg};
        cmd.first_term = (k_reg == '0);
        cmd.last_term  = k_at_end;
        cmd.out_row    = i_reg;
        cmd.out_col    = j_reg;
        cmd.out_last   = i_at_end && j_at_end;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_opcode)
                        OP_WRITE_A: cmd.a_we = row_ok_a && col_ok;
                        OP_WRITE_B: cmd.b_we = row_ok_b && col_ok;
                        OP_COMPUTE: begin
                            i_next     = '0;
                            j_next     = '0;
                            k_next     = '0;
                            state_next = ST_ISSUE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ISSUE: begin
                cmd.rd_en = 1'b1;
                if (k_at_end) begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + DIM_W'(1);
                end
            end
            ST_DRAIN: begin
                if (status.dot_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    if (j_at_end) begin
                        j_next = '0;
                        i_next = i_reg + DIM_W'(1);
                    end else begin
                        j_next = j_reg + DIM_W'(1);
                    end
                    state_next = (i_at_end && j_at_end) ? ST_IDLE : ST_ISSUE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: sv/imm_dpath.sv
module imm_dpath
    import imm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  imm_cmd_t                 cmd,
    input  logic signed [DATA_W-1:0] s_element_value,
    output imm_status_t              status,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [DIM_W-1:0]         m_out_row,
    output logic [DIM_W-1:0]         m_out_col,
    output logic signed [DATA_W-1:0] m_product_value,
    output logic                     m_last
);

    logic [DATA_W-1:0] a_mem [DEPTH];
    logic [DATA_W-1:0] b_mem [DEPTH];

    logic [DATA_W-1:0]   a_q_reg, b_q_reg;
    logic                rd_valid_reg, rd_first_reg, rd_last_reg;
    logic [DATA_W-1:0]   prod_low;
    logic [DATA_W-1:0]   prod_reg;
    logic                mul_valid_reg, mul_first_reg, mul_last_reg;
    logic [DATA_W-1:0]   acc_reg, acc_next;

    logic                     m_valid_reg;
    logic [DIM_W-1:0]         m_row_reg, m_col_reg;
    logic signed [DATA_W-1:0] m_value_reg;
    logic                     m_last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.a_we) begin
            a_mem[cmd.wr_addr] <= s_element_value;
        end
        if (cmd.b_we) begin
            b_mem[cmd.wr_addr] <= s_element_value;
        end
        if (cmd.rd_en) begin
            a_q_reg <= a_mem[cmd.a_rd_addr];
            b_q_reg <= b_mem[cmd.b_rd_addr];
        end
    end

    // only the low word of the product matters; sign does not affect it
    assign prod_low = a_q_reg * b_q_reg;
    assign acc_next = (mul_first_reg ? '0 : acc_reg) + prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_low;
        if (mul_valid_reg) begin
            acc_reg <= acc_next;
        end
        rd_first_reg  <= cmd.first_term;
        rd_last_reg   <= cmd.last_term;
        mul_first_reg <= rd_first_reg;
        mul_last_reg  <= rd_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg  <= cmd.rd_en;
            mul_valid_reg <= rd_valid_reg;
        end
    end

    assign status.dot_done = mul_valid_reg && mul_last_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_row_reg   <= cmd.out_row;
            m_col_reg   <= cmd.out_col;
            m_value_reg <= acc_reg;
            m_last_reg  <= cmd.out_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_row       = m_row_reg;
    assign m_out_col       = m_col_reg;
    assign m_product_value = m_value_reg;
    assign m_last          = m_last_reg;

endmodule

// File: sv/integer_matrix_multiply_core.sv
// Channel    Handshake          Payload
// request    s_valid/s_ready    s_opcode, s_row_index, s_col_index, s_element_value
// result     m_valid/m_ready    m_out_row, m_out_col, m_product_value, m_last
// config     cfg_we             cfg_index, cfg_wdata
//
// Element writes are accepted only while idle. A compute issues cols memory reads per
// result into the single multiply-accumulate unit, then waits while the read, product
// and accumulator registers fill before the sum is moved into the output register.
// A stall on m_ready holds the sequencer before it loads the next result.
// Reset is synchronous on aresetn; A/B stores are not cleared.
module integer_matrix_multiply_core
    import imm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [CFG_W-1:0]         cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OP_W-1:0]          s_opcode,
    input  logic [DIM_W-1:0]         s_row_index,
    input  logic [DIM_W-1:0]         s_col_index,
    input  logic signed [DATA_W-1:0] s_element_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [DIM_W-1:0]         m_out_row,
    output logic [DIM_W-1:0]         m_out_col,
    output logic signed [DATA_W-1:0] m_product_value,
    output logic                     m_last
);

    imm_cmd_t    cmd;
    imm_status_t status;

    imm_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_row_index (s_row_index),
        .s_col_index (s_col_index),
        .status      (status),
        .cmd         (cmd)
    );

    imm_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .s_element_value (s_element_value),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_row       (m_out_row),
        .m_out_col       (m_out_col),
        .m_product_value (m_product_value),
        .m_last          (m_last)
    );

endmodule
